// File: rtl/lmae_pkg.sv
// Shared types, widths and constants of the light meter with auto gain and
// exposure calculation. No dependencies; every other file imports this package.
`default_nettype none

package lmae_pkg;

  // Field and register widths.
  localparam int LUX_W  = 26;
  localparam int GAIN_W = 3;
  localparam int KIND_W = 2;
  localparam int EV_W   = 14;
  localparam int ISO_W  = 24;
  localparam int F_W    = 16;
  localparam int T_W    = 26;
  localparam int C_W    = 10;
  localparam int CFG_W  = 26;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_GAIN_DEF = 4;

  // Configuration reset values.
  localparam logic [F_W-1:0] F_STOP_RST = F_W'(256);
  localparam logic [T_W-1:0] SHUTTER_RST = T_W'(8000);
  localparam logic [C_W-1:0] CAL_RST = C_W'(250);

  // Digit-serial multiplier: 62-bit multiplicand, 32-bit multiplier, 8-bit digits.
  localparam int MUL_W      = 62;
  localparam int MUL_B_W    = 32;
  localparam int DIG_W      = 8;
  localparam int MUL_DIGITS = MUL_B_W / DIG_W;

  // Divider: numerator C*N^2*1e6 fits 62 bits, denominator 256*L*t fits 59 bits.
  localparam int NUM_W     = 62;
  localparam int DEN_W     = 59;
  localparam int DEN_SHIFT = 8;
  localparam logic [ISO_W-1:0] ISO_MAX = '1;
  localparam logic [MUL_B_W-1:0] MEGA = MUL_B_W'(1000000);

  // Log2: mantissa in Q1.30, 16 fraction bits, exponent counter.
  localparam int MANT_W = 31;
  localparam int FRAC_W = 16;
  localparam int K_W    = 5;
  localparam logic [K_W-1:0] K_START = K_W'(MANT_W - 1);
  localparam int EVF_W  = K_W + FRAC_W + 2;
  // log2(640) in Q16 less the rounding half of one Q8 step.
  localparam logic signed [EVF_W-1:0] EV_BIAS = EVF_W'(610922 - 128);
  localparam logic [EV_W-1:0] EV_MIN = {1'b1, {(EV_W-1){1'b0}}};

  // Gain selection: lux * 10 compared against threshold * 256 * tenths.
  localparam int L10_W = 28;
  localparam logic signed [LUX_W-1:0] LUX_LIMIT = LUX_W'(60000 * 256);

  localparam logic [1:0] HYST_08 = 2'd0;
  localparam logic [1:0] HYST_09 = 2'd1;
  localparam logic [1:0] HYST_11 = 2'd2;

  typedef struct packed {
    logic [L10_W-1:0] hi;
    logic [L10_W-1:0] mid;
    logic [L10_W-1:0] lo;
  } thr_t;

  function automatic thr_t thr_of(input logic [1:0] hidx);
    thr_t t;
    case (hidx)
      HYST_08: begin
        t.hi  = L10_W'(1700 * 256 * 8);
        t.mid = L10_W'(100 * 256 * 8);
        t.lo  = L10_W'(5 * 256 * 8);
      end
      HYST_09: begin
        t.hi  = L10_W'(1700 * 256 * 9);
        t.mid = L10_W'(100 * 256 * 9);
        t.lo  = L10_W'(5 * 256 * 9);
      end
      default: begin
        t.hi  = L10_W'(1700 * 256 * 11);
        t.mid = L10_W'(100 * 256 * 11);
        t.lo  = L10_W'(5 * 256 * 11);
      end
    endcase
    return t;
  endfunction

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_F_STOP  = 2'd0,
    CFG_SHUTTER = 2'd1,
    CFG_CAL     = 2'd2
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISCARD = 2'd0,
    KIND_GAIN    = 2'd1,
    KIND_ACCEPT  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_FF  = 2'd0,
    OP_FFC = 2'd1,
    OP_NUM = 2'd2,
    OP_DEN = 2'd3
  } iso_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_NORM,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_ISO_GO,
    ST_ISO_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// File: rtl/lmae_mul.sv
// Digit-serial multiplier: the multiplier operand shifts out one 8-bit digit
// per cycle against the full multiplicand. Depends on lmae_pkg.
`default_nettype none

module lmae_mul import lmae_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_W-1:0]   a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic               done_o,
  output logic [MUL_W-1:0]   prod_o
);

  localparam int DigCntW = $clog2(MUL_DIGITS);

  logic [MUL_W-1:0]       a_q, a_d;
  logic [MUL_W-1:0]       acc_q, acc_d;
  logic [MUL_B_W-1:0]     b_q, b_d;
  logic [DigCntW-1:0]     dig_q, dig_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [MUL_W+DIG_W-1:0] pp;

  always_comb begin
    pp     = a_q * b_q[DIG_W-1:0];
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    dig_d  = dig_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      dig_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The product is below 2^62, so dropping the carries above that is exact.
      acc_d = acc_q + pp[MUL_W-1:0];
      a_d   = a_q << DIG_W;
      b_d   = b_q >> DIG_W;
      dig_d = dig_q + 1'b1;
      if (dig_q == DigCntW'(MUL_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dig_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      dig_q  <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// File: rtl/lmae_div.sv
// Bit-serial restoring divider that yields a 24-bit quotient, saturated at
// its maximum, one quotient bit per cycle. Depends on lmae_pkg.
`default_nettype none

module lmae_div import lmae_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [ISO_W-1:0] quot_o
);

  localparam int CntW = $clog2(ISO_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [ISO_W-1:0] low_q, low_d;
  logic [ISO_W-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   r2;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    r2     = {rem_q, low_q[ISO_W-1]};
    diff   = r2 - {1'b0, den_q};
    ge     = (r2 >= {1'b0, den_q});
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // The upper numerator bits form the first partial remainder.
      rem_d  = DEN_W'(num_i >> ISO_W);
      low_d  = num_i[ISO_W-1:0];
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        // A quotient of 2^24 or more cannot be shown and saturates.
        if (rem_q >= den_q) begin
          quot_d = ISO_MAX;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        rem_d  = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
        quot_d = {quot_q[ISO_W-2:0], ge};
        low_d  = low_q << 1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(ISO_W)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: rtl/light_meter_autogain_exposure.sv
// Light meter with automatic gain selection, exposure value and ISO output.
// Depends on lmae_pkg, lmae_mul and lmae_div.
//
// Usage: one lux reading (signed Q17.8) enters per item on the in_valid_i /
// in_ready_o channel; exactly one result item leaves on out_valid_o /
// out_ready_i. Aperture, shutter time and calibration constant are written
// through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// A discarded reading goes from ST_IDLE straight to ST_OUT; a gain change or a
// reading of zero or less passes through ST_CLASS first. An accepted positive
// reading runs classification, one-bit mantissa normalization, 16 squarings
// and 4 ISO products on the shared 8-bit-digit multiplier, the
// one-bit-per-cycle divider, then EV and the output load; with a zero shutter
// time the ISO products and the divider are skipped.
// One item is worked on at a time.
// A new item is taken as soon as the previous one is finished, even while its
// result still waits in the output register; if the receiver keeps stalling,
// the second item halts just before its own result and in_ready_o stays low.
// Reset sets gain 2 (or the maximum gain if lower), hysteresis factor 0.9,
// arms the discard of the first reading and loads the register defaults.
`default_nettype none

module light_meter_autogain_exposure import lmae_pkg::*; #(
  parameter int unsigned MAX_GAIN = MAX_GAIN_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [LUX_W-1:0] lux_q8_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [KIND_W-1:0]       result_kind_o,
  output logic [GAIN_W-1:0]       gain_out_o,
  output logic signed [LUX_W-1:0] lux_out_o,
  output logic signed [EV_W-1:0]  ev_q8_o,
  output logic [ISO_W-1:0]        iso_out_o
);

  localparam logic [GAIN_W-1:0] GainMax = GAIN_W'(MAX_GAIN);
  localparam logic [GAIN_W-1:0] GainRst = GAIN_W'((MAX_GAIN < 2) ? MAX_GAIN : 2);
  localparam int SqCntW = $clog2(FRAC_W);

  state_e                  state_q, state_d;
  logic [GAIN_W-1:0]       gain_q, gain_d;
  logic [1:0]              hidx_q, hidx_d;
  logic                    disc_q, disc_d;
  logic [F_W-1:0]          f_q;
  logic [T_W-1:0]          t_q;
  logic [C_W-1:0]          c_q;

  logic signed [LUX_W-1:0] lux_q, lux_d;
  logic [MANT_W-1:0]       x_q, x_d;
  logic [K_W-1:0]          k_q, k_d;
  logic [FRAC_W-1:0]       frac_q, frac_d;
  logic [SqCntW-1:0]       sq_cnt_q, sq_cnt_d;
  iso_op_e                 op_q, op_d;
  logic [MUL_W-1:0]        p_q, p_d;
  kind_e                   kind_q, kind_d;
  logic [EV_W-1:0]         ev_q, ev_d;
  logic [ISO_W-1:0]        iso_q, iso_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  kind_e                   out_kind_q;
  logic [GAIN_W-1:0]       out_gain_q;
  logic signed [LUX_W-1:0] out_lux_q;
  logic [EV_W-1:0]         out_ev_q;
  logic [ISO_W-1:0]        out_iso_q;

  logic                    mul_start;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic                    mul_done;
  logic [MUL_W-1:0]        mul_prod;
  logic                    div_start;
  logic [DEN_W-1:0]        div_den;
  logic                    div_done;
  logic [ISO_W-1:0]        div_quot;

  logic                    lux_pos;
  logic                    in_range;
  logic [L10_W-1:0]        lux_mag;
  logic [L10_W-1:0]        l10;
  thr_t                    thr;
  logic [GAIN_W-1:0]       raw_gain;
  logic [GAIN_W-1:0]       next_gain;
  logic [MANT_W:0]         sq;
  logic signed [EVF_W-1:0] ev_full;

  // Gain choice from the held reading and the current hysteresis factor.
  always_comb begin
    lux_pos  = !lux_q[LUX_W-1] && (lux_q != '0);
    in_range = lux_pos && (lux_q <= LUX_LIMIT);
    lux_mag  = L10_W'(lux_q[LUX_W-3:0]);
    l10      = (lux_mag << 3) + (lux_mag << 1);
    thr      = thr_of(hidx_q);
    if (!in_range) begin
      raw_gain = (gain_q == '0) ? '0 : gain_q - 1'b1;
    end else if (l10 > thr.hi) begin
      raw_gain = GAIN_W'(1);
    end else if ((l10 < thr.mid) && (l10 > thr.lo)) begin
      raw_gain = GAIN_W'(3);
    end else if (l10 < thr.lo) begin
      raw_gain = GAIN_W'(4);
    end else begin
      raw_gain = GAIN_W'(2);
    end
    next_gain = (raw_gain > GainMax) ? GainMax : raw_gain;
  end

  // Squared mantissa back in Q1.30 plus one overflow bit, and the final EV.
  assign sq      = mul_prod[2*MANT_W-1 -: MANT_W+1];
  assign ev_full = $signed({2'b00, k_q, frac_q}) - EV_BIAS;
  assign div_den = DEN_W'(mul_prod) << DEN_SHIFT;

  lmae_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  lmae_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p_q),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    gain_d    = gain_q;
    hidx_d    = hidx_q;
    disc_d    = disc_q;
    lux_d     = lux_q;
    x_d       = x_q;
    k_d       = k_q;
    frac_d    = frac_q;
    sq_cnt_d  = sq_cnt_q;
    op_d      = op_q;
    p_d       = p_q;
    kind_d    = kind_q;
    ev_d      = ev_q;
    iso_d     = iso_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          lux_d = lux_q8_i;
          if (disc_q) begin
            disc_d  = 1'b0;
            kind_d  = KIND_DISCARD;
            ev_d    = '0;
            iso_d   = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_CLASS;
          end
        end
      end
      ST_CLASS: begin
        if (next_gain != gain_q) begin
          gain_d = next_gain;
          if (next_gain == GAIN_W'(1)) begin
            hidx_d = HYST_08;
          end else if (next_gain == GAIN_W'(2)) begin
            hidx_d = HYST_09;
          end else if (next_gain >= GAIN_W'(3)) begin
            hidx_d = HYST_11;
          end
          disc_d  = 1'b1;
          kind_d  = KIND_GAIN;
          ev_d    = '0;
          iso_d   = '0;
          state_d = ST_OUT;
        end else begin
          kind_d = KIND_ACCEPT;
          if (!lux_pos) begin
            ev_d    = EV_MIN;
            iso_d   = ISO_MAX;
            state_d = ST_OUT;
          end else begin
            x_d     = MANT_W'(lux_q[LUX_W-2:0]);
            k_d     = K_START;
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        // Shift until the leading one sits at the Q1.30 integer bit.
        if (x_q[MANT_W-1]) begin
          frac_d   = '0;
          sq_cnt_d = '0;
          state_d  = ST_SQ_GO;
        end else begin
          x_d = {x_q[MANT_W-2:0], 1'b0};
          k_d = k_q - 1'b1;
        end
      end
      ST_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(x_q);
        mul_b     = MUL_B_W'(x_q);
        state_d   = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_done) begin
          // A square of two or more yields a one in the fraction and is halved.
          frac_d   = {frac_q[FRAC_W-2:0], sq[MANT_W]};
          x_d      = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
          sq_cnt_d = sq_cnt_q + 1'b1;
          if (sq_cnt_q == SqCntW'(FRAC_W - 1)) begin
            if (t_q == '0) begin
              iso_d   = ISO_MAX;
              state_d = ST_EV;
            end else begin
              op_d    = OP_FF;
              state_d = ST_ISO_GO;
            end
          end else begin
            state_d = ST_SQ_GO;
          end
        end
      end
      ST_ISO_GO: begin
        mul_start = 1'b1;
        case (op_q)
          OP_FF: begin
            mul_a = MUL_W'(f_q);
            mul_b = MUL_B_W'(f_q);
          end
          OP_FFC: begin
            mul_a = p_q;
            mul_b = MUL_B_W'(c_q);
          end
          OP_NUM: begin
            mul_a = p_q;
            mul_b = MEGA;
          end
          default: begin
            mul_a = MUL_W'(t_q);
            mul_b = MUL_B_W'(lux_q[LUX_W-2:0]);
          end
        endcase
        state_d = ST_ISO_WAIT;
      end
      ST_ISO_WAIT: begin
        if (mul_done) begin
          case (op_q)
            OP_FF: begin
              p_d     = mul_prod;
              op_d    = OP_FFC;
              state_d = ST_ISO_GO;
            end
            OP_FFC: begin
              p_d     = mul_prod;
              op_d    = OP_NUM;
              state_d = ST_ISO_GO;
            end
            OP_NUM: begin
              p_d     = mul_prod;
              op_d    = OP_DEN;
              state_d = ST_ISO_GO;
            end
            default: begin
              // The lux-times-shutter product stays in the multiplier for the divider.
              state_d = ST_DIV_GO;
            end
          endcase
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          iso_d   = div_quot;
          state_d = ST_EV;
        end
      end
      ST_EV: begin
        ev_d    = ev_full[EV_W+7:8];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= GainRst;
      hidx_q      <= HYST_09;
      disc_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      hidx_q      <= hidx_d;
      disc_q      <= disc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= F_STOP_RST;
      t_q <= SHUTTER_RST;
      c_q <= CAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_F_STOP:  f_q <= cfg_data_i[F_W-1:0];
        CFG_SHUTTER: t_q <= cfg_data_i[T_W-1:0];
        CFG_CAL:     c_q <= cfg_data_i[C_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    lux_q    <= lux_d;
    x_q      <= x_d;
    k_q      <= k_d;
    frac_q   <= frac_d;
    sq_cnt_q <= sq_cnt_d;
    op_q     <= op_d;
    p_q      <= p_d;
    kind_q   <= kind_d;
    ev_q     <= ev_d;
    iso_q    <= iso_d;
    if (out_load) begin
      out_kind_q <= kind_q;
      out_gain_q <= gain_q;
      out_lux_q  <= (kind_q == KIND_ACCEPT) ? lux_q : '0;
      out_ev_q   <= ev_q;
      out_iso_q  <= iso_q;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign gain_out_o    = out_gain_q;
  assign lux_out_o     = out_lux_q;
  assign ev_q8_o       = out_ev_q;
  assign iso_out_o     = out_iso_q;

  // A gain change always arms the discard and goes straight to the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLASS) && (next_gain != gain_q) |=>
      disc_q && (state_q == ST_OUT) && (gain_q <= GainMax))
    else $error("gain change did not arm the discard");

  // Every squaring starts from a normalized mantissa.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ_GO) |-> x_q[MANT_W-1])
    else $error("log2 mantissa not normalized");

  // Only accepted readings carry lux and ISO values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o != KIND_ACCEPT) |->
      (lux_out_o == '0) && (iso_out_o == '0) && (ev_q8_o == '0))
    else $error("non-accepted result carries data");

endmodule

`default_nettype wire
